[hdl/hse_pkg.sv]
// ----------------------------------------------------------------------------
// Hermite spline evaluator package
// Shared constants, codes, types and saturation helpers.
// ----------------------------------------------------------------------------
package hse_pkg;

   localparam int MAX_KNOTS_DEF = 64;
   localparam int AXES_DEF      = 4;
   localparam int FRAC_BITS_DEF = 16;
   localparam int AXES_MAX      = 4;

   localparam int REQ_DATA_W = 296;
   localparam int RSP_DATA_W = 136;

   localparam logic signed [63:0] LIM62  = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] LIM47  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] MAX32  = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] MIN32  = -64'sh0000_0000_8000_0000;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_EVAL  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_INCR  = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   localparam logic [2:0] ORD_POS  = 3'd0;
   localparam logic [2:0] ORD_VEL  = 3'd1;
   localparam logic [2:0] ORD_ACC  = 3'd2;
   localparam logic [2:0] ORD_JERK = 3'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_ROW_RD,
      ST_ROW_LOAD,
      ST_EVAL_MUL,
      ST_EVAL_WAIT,
      ST_AXIS_DONE,
      ST_PUSH_MUL,
      ST_PUSH_MUL_WAIT,
      ST_PUSH_DIV,
      ST_PUSH_DIV_WAIT,
      ST_PUSH_WRITE,
      ST_RESPOND
   } hse_state_type;

   typedef struct packed {
      logic signed [47:0] a;
      logic signed [47:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
   } coef_row_type;

   function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                    input logic signed [63:0] lim);
      logic signed [63:0] r;
      if (v > lim) r = lim;
      else if (v < -lim) r = -lim;
      else r = v;
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v > MAX32) r = MAX32;
      else if (v < MIN32) r = MIN32;
      else r = v;
      return r[31:0];
   endfunction

endpackage

[hdl/hermite_spline_evaluator_top.sv]
// ----------------------------------------------------------------------------
// Hermite spline evaluator
// Multi-axis cubic Hermite trajectory store with knot push and evaluation.
// ----------------------------------------------------------------------------
// Push a knot (opcode push) with its time, positions and velocities; every
// later knot must carry a strictly greater time and closes one segment whose
// cubic coefficients are built with one shared multiplier and one bit-serial
// divider. Evaluate (opcode evaluate) returns position, velocity, acceleration
// or jerk per axis in signed Q16.16, saturated; queries outside the knot range
// clamp to the ends with acceleration zeroed. Clear drops all knots. One beat
// in gives one beat out, and the block takes one beat at a time. A push spends
// most of its time in the five divides per axis of the bit-serial divider. An
// evaluate walks the stored knot times in a linear scan, then runs the
// multiplier chain for each axis. Clear, no-op and rejected beats go straight
// to the response. The knot time and coefficient stores hold no reset
// value; only entries written since the last clear are ever read.
// ----------------------------------------------------------------------------
module hermite_spline_evaluator_top #(
   parameter int MAX_KNOTS = hse_pkg::MAX_KNOTS_DEF,
   parameter int AXES      = hse_pkg::AXES_DEF,
   parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: time_stamp[31:0], derivative_order[34:32], position_axis0..3
   // [66:35],[98:67],[130:99],[162:131], velocity_axis0..3 [194:163],
   // [226:195],[258:227],[290:259], zero fill [295:291]
   input  logic [hse_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]                        req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: piece_index[5:0], value_axis0..3 [37:6],[69:38],[101:70],
   // [133:102], zero fill [135:134]
   output logic [hse_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: status[1:0]
   output logic [1:0]                        rsp_tuser
);
   import hse_pkg::*;

   localparam int KW  = $clog2(MAX_KNOTS);
   localparam int CW  = $clog2(MAX_KNOTS + 1);
   localparam int AXB = (AXES > 1) ? $clog2(AXES) : 1;

   hse_state_type state_ff, state_in;

   // latched request
   logic [1:0]  req_op_ff;
   logic [31:0] req_time_ff;
   logic [2:0]  req_ord_ff;
   logic [31:0] req_pos_ff [AXES];
   logic [31:0] req_vel_ff [AXES];

   // spline state
   logic [CW-1:0] count_ff;
   logic [31:0]   first_time_ff;
   logic [31:0]   last_time_ff;
   logic [31:0]   penult_time_ff;
   logic [31:0]   prev_pos_ff [AXES];
   logic [31:0]   prev_vel_ff [AXES];

   // stores
   logic [31:0]  time_mem [MAX_KNOTS];
   coef_row_type coef_mem [MAX_KNOTS << AXB];
   logic [31:0]  time_rd_ff;
   coef_row_type coef_rd_ff;

   // working registers
   logic [31:0]        tau_ff;
   logic [31:0]        s_ff;
   logic [KW-1:0]      k_ff;
   logic [AXB-1:0]     ax_ff;
   logic [KW-1:0]      scan_idx_ff;
   logic [31:0]        scan_prev_ff;
   logic               edge_ff;
   logic               phase_ff;
   logic [1:0]         div_cnt_ff;
   logic [1:0]         step_ff;
   logic signed [63:0] h_ff;
   logic signed [47:0] a_keep_ff;
   logic [1:0]         status_ff;
   logic [31:0]        val_ff [AXES_MAX];

   // output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0]            rsp_status_ff;

   // shared units
   logic               mul_start, mul_done, div_start, div_done;
   logic signed [63:0] mul_x, mul_res, div_res;
   logic [31:0]        mul_s;

   // decisions
   logic push_late, push_full, eval_few, eval_lo, eval_hi, scan_hit;
   logic ax_last, mac_needed, step_last, div_last, rsp_free;

   logic signed [63:0] x0, v0, x1, v1, dx, a64, b64, c64, d64, a3, a6;
   logic signed [63:0] addend, mac_sum, push_num;
   logic [1:0]         last_step;

   hse_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
      .clock(clock), .reset(reset), .start(mul_start), .x(mul_x), .s(mul_s),
      .done(mul_done), .result(mul_res)
   );

   hse_divq #(.FRAC_BITS(FRAC_BITS)) u_divq (
      .clock(clock), .reset(reset), .start(div_start), .x(h_ff), .s(tau_ff),
      .done(div_done), .result(div_res)
   );

   // operand decode
   always_comb begin
      x0  = {{32{prev_pos_ff[ax_ff][31]}}, prev_pos_ff[ax_ff]};
      v0  = {{32{prev_vel_ff[ax_ff][31]}}, prev_vel_ff[ax_ff]};
      x1  = {{32{req_pos_ff[ax_ff][31]}}, req_pos_ff[ax_ff]};
      v1  = {{32{req_vel_ff[ax_ff][31]}}, req_vel_ff[ax_ff]};
      dx  = x1 - x0;
      a64 = {{16{coef_rd_ff.a[47]}}, coef_rd_ff.a};
      b64 = {{16{coef_rd_ff.b[47]}}, coef_rd_ff.b};
      c64 = {{32{coef_rd_ff.c[31]}}, coef_rd_ff.c};
      d64 = {{32{coef_rd_ff.d[31]}}, coef_rd_ff.d};
      a3  = (a64 <<< 1) + a64;
      a6  = a3 <<< 1;

      // first Horner step scales a and b by the derivative order
      unique case (step_ff)
         2'd0:    addend = (req_ord_ff == ORD_POS) ? b64 : (b64 <<< 1);
         2'd1:    addend = c64;
         default: addend = d64;
      endcase
      mac_sum = clamp_sym(mul_res + addend, LIM62);

      if (state_ff == ST_PUSH_MUL || state_ff == ST_PUSH_MUL_WAIT) begin
         mul_x = phase_ff ? ((v0 <<< 1) + v1) : (v0 + v1);
         mul_s = tau_ff;
      end else begin
         if (step_ff != 2'd0) mul_x = h_ff;
         else if (req_ord_ff == ORD_POS) mul_x = a64;
         else if (req_ord_ff == ORD_VEL) mul_x = a3;
         else mul_x = a6;
         mul_s = s_ff;
      end
      push_num = phase_ff ? ((dx <<< 1) + dx - mul_res) : (mul_res - (dx <<< 1));

      unique case (req_ord_ff)
         ORD_POS: last_step = 2'd2;
         ORD_VEL: last_step = 2'd1;
         default: last_step = 2'd0;
      endcase
   end

   always_comb begin
      push_late  = req_time_ff <= last_time_ff;
      push_full  = count_ff >= CW'(MAX_KNOTS);
      eval_few   = count_ff < CW'(2);
      eval_lo    = req_time_ff <= first_time_ff;
      eval_hi    = req_time_ff >= last_time_ff;
      scan_hit   = time_rd_ff >= req_time_ff;
      ax_last    = ax_ff == AXB'(AXES - 1);
      mac_needed = (req_ord_ff == ORD_POS) || (req_ord_ff == ORD_VEL) ||
                   (req_ord_ff == ORD_ACC && !edge_ff);
      step_last  = step_ff == last_step;
      div_last   = div_cnt_ff == (phase_ff ? 2'd1 : 2'd2);
      rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   // sequencer: next state and unit starts
   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (req_op_ff)
               OP_PUSH: begin
                  if (count_ff == '0 || push_late || push_full) state_in = ST_RESPOND;
                  else state_in = ST_PUSH_MUL;
               end
               OP_EVAL: begin
                  if (eval_few) state_in = ST_RESPOND;
                  else if (eval_lo || eval_hi) state_in = ST_ROW_RD;
                  else state_in = ST_SCAN_RD;
               end
               default: state_in = ST_RESPOND;
            endcase
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = scan_hit ? ST_ROW_RD : ST_SCAN_RD;
         ST_ROW_RD: state_in = ST_ROW_LOAD;
         ST_ROW_LOAD: state_in = mac_needed ? ST_EVAL_MUL : ST_AXIS_DONE;
         ST_EVAL_MUL: begin
            mul_start = 1'b1;
            state_in  = ST_EVAL_WAIT;
         end
         ST_EVAL_WAIT: begin
            if (mul_done) state_in = step_last ? ST_AXIS_DONE : ST_EVAL_MUL;
         end
         ST_AXIS_DONE: state_in = ax_last ? ST_RESPOND : ST_ROW_RD;
         ST_PUSH_MUL: begin
            mul_start = 1'b1;
            state_in  = ST_PUSH_MUL_WAIT;
         end
         ST_PUSH_MUL_WAIT: if (mul_done) state_in = ST_PUSH_DIV;
         ST_PUSH_DIV: begin
            div_start = 1'b1;
            state_in  = ST_PUSH_DIV_WAIT;
         end
         ST_PUSH_DIV_WAIT: begin
            if (div_done) begin
               if (!div_last) state_in = ST_PUSH_DIV;
               else state_in = phase_ff ? ST_PUSH_WRITE : ST_PUSH_MUL;
            end
         end
         ST_PUSH_WRITE: state_in = ax_last ? ST_RESPOND : ST_PUSH_MUL;
         ST_RESPOND: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // stores: registered reads every cycle
   always_ff @(posedge clock) begin
      time_rd_ff <= time_mem[scan_idx_ff];
      coef_rd_ff <= coef_mem[{k_ff, ax_ff}];
      if (state_ff == ST_DISPATCH && req_op_ff == OP_PUSH && count_ff == '0) begin
         time_mem[0] <= req_time_ff;
      end else if (state_ff == ST_PUSH_WRITE && ax_last) begin
         time_mem[count_ff[KW-1:0]] <= req_time_ff;
      end
      if (state_ff == ST_PUSH_WRITE) begin
         coef_mem[{k_ff, ax_ff}] <= '{a: a_keep_ff,
                                      b: 48'(clamp_sym(h_ff, LIM47)),
                                      c: prev_vel_ff[ax_ff],
                                      d: prev_pos_ff[ax_ff]};
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DISPATCH) begin
            if (req_op_ff == OP_CLEAR) count_ff <= '0;
            else if (req_op_ff == OP_PUSH && count_ff == '0) count_ff <= CW'(1);
         end
         if (state_ff == ST_PUSH_WRITE && ax_last) count_ff <= count_ff + CW'(1);
         if (state_ff == ST_RESPOND && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            // hold the beat for the whole operation
            if (req_tvalid) begin
               req_op_ff   <= req_tuser;
               req_time_ff <= req_tdata[31:0];
               req_ord_ff  <= req_tdata[34:32];
               for (int i = 0; i < AXES; i++) begin
                  req_pos_ff[i] <= req_tdata[35 + 32*i +: 32];
                  req_vel_ff[i] <= req_tdata[163 + 32*i +: 32];
               end
            end
         end
         ST_DISPATCH: begin
            status_ff    <= STATUS_OK;
            ax_ff        <= '0;
            phase_ff     <= 1'b0;
            step_ff      <= 2'd0;
            div_cnt_ff   <= 2'd0;
            scan_idx_ff  <= KW'(1);
            scan_prev_ff <= first_time_ff;
            k_ff         <= '0;
            for (int i = 0; i < AXES_MAX; i++) val_ff[i] <= '0;
            if (req_op_ff == OP_PUSH) begin
               if (count_ff == '0) begin
                  for (int i = 0; i < AXES; i++) begin
                     prev_pos_ff[i] <= req_pos_ff[i];
                     prev_vel_ff[i] <= req_vel_ff[i];
                  end
                  first_time_ff <= req_time_ff;
                  last_time_ff  <= req_time_ff;
               end else if (push_late) begin
                  status_ff <= STATUS_NOT_INCR;
               end else if (push_full) begin
                  status_ff <= STATUS_FULL;
               end else begin
                  tau_ff <= req_time_ff - last_time_ff;
                  k_ff   <= KW'(count_ff - CW'(1));
               end
            end else if (req_op_ff == OP_EVAL) begin
               if (eval_few) begin
                  status_ff <= STATUS_EMPTY;
               end else if (eval_lo) begin
                  s_ff    <= '0;
                  edge_ff <= 1'b1;
               end else if (eval_hi) begin
                  k_ff    <= KW'(count_ff - CW'(2));
                  s_ff    <= last_time_ff - penult_time_ff;
                  edge_ff <= 1'b1;
               end else begin
                  edge_ff <= 1'b0;
               end
            end
         end
         ST_SCAN_CMP: begin
            // first stored time at or above the query closes the segment
            if (scan_hit) begin
               k_ff <= scan_idx_ff - KW'(1);
               s_ff <= req_time_ff - scan_prev_ff;
            end else begin
               scan_prev_ff <= time_rd_ff;
               scan_idx_ff  <= scan_idx_ff + KW'(1);
            end
         end
         ST_ROW_LOAD: begin
            step_ff <= 2'd0;
            h_ff    <= (req_ord_ff == ORD_JERK) ? a6 : 64'sd0;
         end
         ST_EVAL_WAIT: begin
            if (mul_done) begin
               h_ff    <= mac_sum;
               step_ff <= step_ff + 2'd1;
            end
         end
         ST_AXIS_DONE: begin
            val_ff[2'(ax_ff)] <= sat32(h_ff);
            ax_ff             <= ax_ff + AXB'(1);
         end
         ST_PUSH_MUL_WAIT: begin
            if (mul_done) begin
               h_ff       <= push_num;
               div_cnt_ff <= 2'd0;
            end
         end
         ST_PUSH_DIV_WAIT: begin
            if (div_done) begin
               h_ff       <= div_res;
               div_cnt_ff <= div_cnt_ff + 2'd1;
               if (div_last && !phase_ff) begin
                  a_keep_ff <= 48'(clamp_sym(div_res, LIM47));
                  phase_ff  <= 1'b1;
               end
            end
         end
         ST_PUSH_WRITE: begin
            // advance the previous knot to the new one for this axis
            prev_pos_ff[ax_ff] <= req_pos_ff[ax_ff];
            prev_vel_ff[ax_ff] <= req_vel_ff[ax_ff];
            phase_ff           <= 1'b0;
            ax_ff              <= ax_ff + AXB'(1);
            if (ax_last) begin
               penult_time_ff <= last_time_ff;
               last_time_ff   <= req_time_ff;
            end
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               rsp_status_ff <= status_ff;
               rsp_data_ff   <= {2'b00, val_ff[3], val_ff[2], val_ff[1], val_ff[0],
                                 (req_op_ff == OP_EVAL && status_ff == STATUS_OK) ?
                                 6'(k_ff) : 6'd0};
            end
         end
         default: ;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   // a taken beat keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // any error status carries all-zero values and piece index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> (rsp_tdata[133:0] == '0))
      else $error("error response with nonzero payload");

   // knot count never passes the table size
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff <= CW'(MAX_KNOTS)))
      else $error("knot count overflow");

endmodule

[hdl/hse_mulq.sv]
// ----------------------------------------------------------------------------
// Hermite spline fixed-point multiplier
// Computes x * s / 2^FRAC_BITS, truncated toward zero and saturated, with one
// shared 32x32 multiplier over two partial products.
// ----------------------------------------------------------------------------
module hse_mulq #(
   parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  x,
   input  logic [31:0]         s,
   output logic                done,
   output logic signed [63:0]  result
);
   import hse_pkg::*;

   localparam int SH = 32 - FRAC_BITS;
   localparam logic [63:0] HI_LIM = 64'(LIM62) >> SH;

   logic [1:0]  cnt_ff;
   logic        neg_ff;
   logic [63:0] mag_ff;
   logic [31:0] s_ff;
   logic [63:0] hi_prod_ff;
   logic [63:0] lo_prod_ff;
   logic [31:0] mul_op;
   logic [63:0] prod;
   logic [63:0] sum;
   logic [63:0] mag_out;

   // one multiplier: high half first, then low half
   assign mul_op = (cnt_ff == 2'd1) ? mag_ff[63:32] : mag_ff[31:0];
   assign prod   = {32'd0, mul_op} * {32'd0, s_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         unique case (cnt_ff)
            2'd0: if (start) cnt_ff <= 2'd1;
            2'd1: cnt_ff <= 2'd2;
            2'd2: cnt_ff <= 2'd3;
            default: cnt_ff <= 2'd0;
         endcase
      end
      if (cnt_ff == 2'd0 && start) begin
         neg_ff <= x[63];
         mag_ff <= x[63] ? 64'(-x) : 64'(x);
         s_ff   <= s;
      end
      if (cnt_ff == 2'd1) hi_prod_ff <= prod;
      if (cnt_ff == 2'd2) lo_prod_ff <= prod;
   end

   always_comb begin
      sum = (hi_prod_ff << SH) + (lo_prod_ff >> FRAC_BITS);
      if (hi_prod_ff > HI_LIM || sum > 64'(LIM62)) mag_out = 64'(LIM62);
      else mag_out = sum;
   end

   assign done   = (cnt_ff == 2'd3);
   assign result = neg_ff ? -$signed(mag_out) : $signed(mag_out);

endmodule

[hdl/hse_divq.sv]
// ----------------------------------------------------------------------------
// Hermite spline fixed-point divider
// Computes x * 2^FRAC_BITS / s, truncated toward zero and saturated, one
// quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module hse_divq #(
   parameter int FRAC_BITS = hse_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  x,
   input  logic [31:0]         s,
   output logic                done,
   output logic signed [63:0]  result
);
   import hse_pkg::*;

   localparam int STEPS = 64 + FRAC_BITS;
   localparam int CNTW  = $clog2(STEPS + 1);

   logic            busy_ff;
   logic            fin_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            neg_ff;
   logic [31:0]     s_ff;
   logic [63:0]     dvd_ff;
   logic [32:0]     rem_ff;
   logic [62:0]     quo_ff;
   logic            ovf_ff;
   logic [32:0]     rem_sh;
   logic            ge;
   logic            sat;
   logic [63:0]     mag_out;

   assign rem_sh = {rem_ff[31:0], dvd_ff[63]};
   assign ge     = rem_sh >= {1'b0, s_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         fin_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNTW'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end
      if (start && !busy_ff) begin
         cnt_ff <= '0;
         neg_ff <= x[63];
         dvd_ff <= x[63] ? 64'(-x) : 64'(x);
         s_ff   <= s;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNTW'(1);
         dvd_ff <= {dvd_ff[62:0], 1'b0};
         rem_ff <= ge ? rem_sh - {1'b0, s_ff} : rem_sh;
         quo_ff <= {quo_ff[61:0], ge};
         ovf_ff <= ovf_ff | quo_ff[62];
      end
   end

   // a zero divisor yields all ones and lands in saturation
   assign sat     = ovf_ff | quo_ff[62];
   assign mag_out = sat ? 64'(LIM62) : {1'b0, quo_ff};
   assign done    = fin_ff;
   assign result  = neg_ff ? -$signed(mag_out) : $signed(mag_out);

endmodule
